@@ hdl/audio_level_meter_multichannel_macros.svh @@
// Assertion helpers for the level meter.
`ifndef AUDIO_LEVEL_METER_MULTICHANNEL_MACROS_SVH
`define AUDIO_LEVEL_METER_MULTICHANNEL_MACROS_SVH

// same-cycle implication
`define ALM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ALM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/alm_pkg.sv @@
`default_nettype none
package alm_pkg;

    localparam int SUM_W = 64;
    localparam logic [20:0] K_Q16 = 21'd1972830;
    localparam logic [10:0] FLOOR_TENTHS = 11'd1200;
    localparam logic signed [11:0] LVL_FLOOR = -12'sd1200;
    localparam logic signed [11:0] THR_RESET = -12'sd600;

    typedef enum logic [1:0] {
        FN_ACCUM  = 2'd0,
        FN_REPORT = 2'd1,
        FN_CLEAR  = 2'd2,
        FN_NONE   = 2'd3
    } t_func;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACC_SQ,
        S_ACC_ADD,
        S_CNT_GO,
        S_CNT_WT,
        S_PK_GO,
        S_PK_WT,
        S_LVL_PK,
        S_RMS_GO,
        S_RMS_WT,
        S_LVL_RMS,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        L_IDLE,
        L_NORM8,
        L_NORM1,
        L_FRAC
    } t_lg_state;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] res;
    } t_lg_stat;

    // log2 in Q.16, used for elaboration-time constants only
    function automatic logic [31:0] lg2_const(input logic [63:0] x);
        logic [63:0] v;
        logic [6:0]  e;
        logic [63:0] p;
        logic [32:0] t;
        logic [31:0] m;
        logic [15:0] fr;
        v = x;
        e = 7'd63;
        for (int k = 0; k < 63; k++) begin
            if (!v[63]) begin
                v = v << 1;
                e = e - 7'd1;
            end
        end
        m  = v[63:32];
        fr = '0;
        for (int k = 0; k < 16; k++) begin
            p  = {32'd0, m} * {32'd0, m};
            t  = p[63:31];
            fr = {fr[14:0], t[32]};
            m  = t[32] ? t[32:1] : t[31:0];
        end
        return {9'd0, e, fr};
    endfunction

    // tenths of dB below full scale, rounded, clamped at the floor
    function automatic logic signed [11:0] level_tenths(input logic [31:0] num,
                                                        input logic [31:0] den);
        logic [53:0] prod;
        logic [21:0] r;
        if (num >= den) return 12'sd0;
        prod = 54'(den - num) * 54'(K_Q16);
        prod = prod + (54'd1 << 31);
        r    = prod[53:32];
        if (r > 22'(FLOOR_TENTHS)) return LVL_FLOOR;
        return -$signed({1'b0, r[10:0]});
    endfunction

endpackage
`default_nettype wire

@@ hdl/audio_level_meter_multichannel.sv @@
`default_nettype none
// Multichannel audio peak / RMS level meter.
// Input channel: i_valid / o_stall, with i_func and one sample port per channel.
// A beat is taken when i_valid is high and o_stall low; o_stall is high while
// an item is being worked on.
//   accumulate: one shared squarer handles one channel at a time, squaring
//     then adding, updating peak, saturating sum of squares and frame count.
//   report: one result beat per channel on o_valid / i_stall, last on the top
//     channel. Each channel runs up to two passes of the shared log2 unit
//     (normalize by bytes, then by bits, then one squaring per fraction bit);
//     a pass is skipped, its level at the floor, when the peak or sum is zero;
//     plus one log2 pass of the frame count per report when it is not zero.
//   clear: all accumulators and the count go to zero.
// The output beat sits in a register; the block keeps computing the next
// channel while it waits and only holds when that register is still full.
// A new input beat is taken while the final result still waits to be taken.
// Reset (i_rst_n low, synchronous) clears the accumulators, the count and
// drops o_valid; the threshold returns to -60.0 dB. The user writes the
// threshold via i_cfg_wr_en / i_cfg_wr_data only while idle; not enforced.
module audio_level_meter_multichannel #(
    parameter int CHANNELS         = 8,
    parameter int SAMPLE_BITS      = 24,
    parameter int FRAME_COUNT_BITS = 18
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wr_en,
    input  wire logic signed [11:0] i_cfg_wr_data,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [1:0]         i_func,
    input  wire logic signed [23:0] i_sample_ch0,
    input  wire logic signed [23:0] i_sample_ch1,
    input  wire logic signed [23:0] i_sample_ch2,
    input  wire logic signed [23:0] i_sample_ch3,
    input  wire logic signed [23:0] i_sample_ch4,
    input  wire logic signed [23:0] i_sample_ch5,
    input  wire logic signed [23:0] i_sample_ch6,
    input  wire logic signed [23:0] i_sample_ch7,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [2:0]              o_channel,
    output logic signed [11:0]      o_peak_tenths_db,
    output logic signed [11:0]      o_rms_tenths_db,
    output logic                    o_active,
    output logic                    o_last
);
    import alm_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);
    localparam logic [63:0] FS = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
    localparam logic [31:0] LF = lg2_const(FS * FS);
    localparam logic [FRAME_COUNT_BITS-1:0] CNT_MAX = '1;

    t_state                    r_state, n_state;
    logic [SAMPLE_BITS-1:0]    r_smp  [CHANNELS];
    logic [SAMPLE_BITS-1:0]    n_smp  [CHANNELS];
    logic [SAMPLE_BITS-1:0]    r_peak [CHANNELS];
    logic [SAMPLE_BITS-1:0]    n_peak [CHANNELS];
    logic [SUM_W-1:0]          r_sum  [CHANNELS];
    logic [SUM_W-1:0]          n_sum  [CHANNELS];
    logic [FRAME_COUNT_BITS-1:0] r_cnt, n_cnt;
    logic [CH_W-1:0]           r_ch, n_ch;
    logic [SAMPLE_BITS-1:0]    r_mag, n_mag;
    logic [2*SAMPLE_BITS-1:0]  r_sq, n_sq;
    logic [31:0]               r_lgc, n_lgc;
    logic [31:0]               r_lgv, n_lgv;
    logic signed [11:0]        r_pkl, n_pkl;
    logic signed [11:0]        r_rml, n_rml;
    logic signed [11:0]        r_thr, n_thr;
    logic                      r_ov, n_ov;
    logic [2:0]                r_och, n_och;
    logic signed [11:0]        r_opk, n_opk;
    logic signed [11:0]        r_orm, n_orm;
    logic                      r_oact, n_oact;
    logic                      r_olast, n_olast;

    logic signed [23:0]        w_in [8];
    logic signed [SAMPLE_BITS-1:0] w_s;
    logic [SUM_W:0]            w_add;
    logic                      w_lg_start;
    logic [63:0]               w_lg_x;
    t_lg_stat                  w_lg;

    assign w_in[0] = i_sample_ch0;
    assign w_in[1] = i_sample_ch1;
    assign w_in[2] = i_sample_ch2;
    assign w_in[3] = i_sample_ch3;
    assign w_in[4] = i_sample_ch4;
    assign w_in[5] = i_sample_ch5;
    assign w_in[6] = i_sample_ch6;
    assign w_in[7] = i_sample_ch7;

    alm_lg2 u_lg2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_lg_start),
        .i_x     (w_lg_x),
        .o_stat  (w_lg)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_thr   <= THR_RESET;
            r_ov    <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_peak[c] <= '0;
                r_sum[c]  <= '0;
            end
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_thr   <= n_thr;
            r_ov    <= n_ov;
            r_peak  <= n_peak;
            r_sum   <= n_sum;
        end
        r_smp   <= n_smp;
        r_ch    <= n_ch;
        r_mag   <= n_mag;
        r_sq    <= n_sq;
        r_lgc   <= n_lgc;
        r_lgv   <= n_lgv;
        r_pkl   <= n_pkl;
        r_rml   <= n_rml;
        r_och   <= n_och;
        r_opk   <= n_opk;
        r_orm   <= n_orm;
        r_oact  <= n_oact;
        r_olast <= n_olast;
    end

    assign w_s   = $signed(r_smp[r_ch]);
    assign w_add = {1'b0, r_sum[r_ch]} + (SUM_W + 1)'(r_sq);

    always_comb begin
        n_state    = r_state;
        n_smp      = r_smp;
        n_peak     = r_peak;
        n_sum      = r_sum;
        n_cnt      = r_cnt;
        n_ch       = r_ch;
        n_mag      = r_mag;
        n_sq       = r_sq;
        n_lgc      = r_lgc;
        n_lgv      = r_lgv;
        n_pkl      = r_pkl;
        n_rml      = r_rml;
        n_thr      = i_cfg_wr_en ? i_cfg_wr_data : r_thr;
        n_ov       = r_ov && i_stall;
        n_och      = r_och;
        n_opk      = r_opk;
        n_orm      = r_orm;
        n_oact     = r_oact;
        n_olast    = r_olast;
        w_lg_start = 1'b0;
        w_lg_x     = '0;
        o_stall    = (r_state != S_IDLE);

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_ch = '0;
                    case (i_func)
                        FN_ACCUM: begin
                            for (int c = 0; c < CHANNELS; c++)
                                n_smp[c] = w_in[c][SAMPLE_BITS-1:0];
                            n_state = S_ACC_SQ;
                        end
                        FN_REPORT: n_state = (r_cnt != '0) ? S_CNT_GO : S_PK_GO;
                        FN_CLEAR: begin
                            for (int c = 0; c < CHANNELS; c++) begin
                                n_peak[c] = '0;
                                n_sum[c]  = '0;
                            end
                            n_cnt = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_ACC_SQ: begin
                n_mag   = w_s[SAMPLE_BITS-1] ? SAMPLE_BITS'(-w_s) : SAMPLE_BITS'(w_s);
                n_sq    = (2*SAMPLE_BITS)'(n_mag) * (2*SAMPLE_BITS)'(n_mag);
                n_state = S_ACC_ADD;
            end
            S_ACC_ADD: begin
                if (r_mag > r_peak[r_ch]) n_peak[r_ch] = r_mag;
                n_sum[r_ch] = w_add[SUM_W] ? '1 : w_add[SUM_W-1:0];
                if (r_ch == CH_LAST) begin
                    if (r_cnt != CNT_MAX) n_cnt = r_cnt + 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_ch    = r_ch + 1'b1;
                    n_state = S_ACC_SQ;
                end
            end
            S_CNT_GO: begin
                w_lg_start = 1'b1;
                w_lg_x     = 64'(r_cnt);
                n_state    = S_CNT_WT;
            end
            S_CNT_WT: begin
                if (w_lg.done) begin
                    n_lgc   = w_lg.res;
                    n_state = S_PK_GO;
                end
            end
            S_PK_GO: begin
                if (r_peak[r_ch] == '0) begin
                    n_pkl   = LVL_FLOOR;
                    n_state = S_RMS_GO;
                end else begin
                    w_lg_start = 1'b1;
                    w_lg_x     = 64'((2*SAMPLE_BITS)'(r_peak[r_ch]) *
                                     (2*SAMPLE_BITS)'(r_peak[r_ch]));
                    n_state    = S_PK_WT;
                end
            end
            S_PK_WT: begin
                if (w_lg.done) begin
                    n_lgv   = w_lg.res;
                    n_state = S_LVL_PK;
                end
            end
            S_LVL_PK: begin
                n_pkl   = level_tenths(r_lgv, LF);
                n_state = S_RMS_GO;
            end
            S_RMS_GO: begin
                if (r_cnt == '0 || r_sum[r_ch] == '0) begin
                    n_rml   = LVL_FLOOR;
                    n_state = S_OUT;
                end else begin
                    w_lg_start = 1'b1;
                    w_lg_x     = r_sum[r_ch];
                    n_state    = S_RMS_WT;
                end
            end
            S_RMS_WT: begin
                if (w_lg.done) begin
                    n_lgv   = w_lg.res;
                    n_state = S_LVL_RMS;
                end
            end
            S_LVL_RMS: begin
                n_rml   = level_tenths(r_lgv, r_lgc + LF);
                n_state = S_OUT;
            end
            S_OUT: begin
                // wait for the output register to free up
                if (!r_ov || !i_stall) begin
                    n_ov    = 1'b1;
                    n_och   = 3'(r_ch);
                    n_opk   = r_pkl;
                    n_orm   = r_rml;
                    n_oact  = (r_pkl >= r_thr);
                    n_olast = (r_ch == CH_LAST);
                    if (r_ch == CH_LAST) begin
                        n_state = S_IDLE;
                    end else begin
                        n_ch    = r_ch + 1'b1;
                        n_state = S_PK_GO;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_valid          = r_ov;
    assign o_channel        = r_och;
    assign o_peak_tenths_db = r_opk;
    assign o_rms_tenths_db  = r_orm;
    assign o_active         = r_oact;
    assign o_last           = r_olast;

`include "audio_level_meter_multichannel_macros.svh"

    `ALM_ASSERT_IMP(a_lg_start_idle, w_lg_start, !w_lg.busy, "log2 unit started while busy")
    `ALM_ASSERT_IMP(a_last_chan, o_valid && o_last, o_channel == 3'(CH_LAST), "last on wrong channel")
    `ALM_ASSERT_NXT(a_report_busy, i_valid && !o_stall && i_func == FN_REPORT,
        r_state != S_IDLE, "report beat did not start the sequencer")
    `ALM_ASSERT_NXT(a_cnt_mono, !(i_valid && !o_stall && i_func == FN_CLEAR),
        r_cnt >= $past(r_cnt), "frame count went down without a clear")

endmodule
`default_nettype wire

@@ hdl/alm_lg2.sv @@
`default_nettype none
module alm_lg2 (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [63:0]        i_x,
    output alm_pkg::t_lg_stat       o_stat
);
    import alm_pkg::*;

    t_lg_state   r_state, n_state;
    logic [63:0] r_x, n_x;
    logic [5:0]  r_sh, n_sh;
    logic [31:0] r_m, n_m;
    logic [15:0] r_fr, n_fr;
    logic [3:0]  r_i, n_i;
    logic        r_done, n_done;
    logic [63:0] w_sq;
    logic [32:0] w_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_x  <= n_x;
        r_sh <= n_sh;
        r_m  <= n_m;
        r_fr <= n_fr;
        r_i  <= n_i;
    end

    assign w_sq = {32'd0, r_m} * {32'd0, r_m};
    assign w_t  = w_sq[63:31];

    always_comb begin
        n_state = r_state;
        n_x     = r_x;
        n_sh    = r_sh;
        n_m     = r_m;
        n_fr    = r_fr;
        n_i     = r_i;
        n_done  = 1'b0;
        unique case (r_state)
            L_IDLE: begin
                if (i_start) begin
                    n_x     = i_x;
                    n_sh    = '0;
                    n_state = L_NORM8;
                end
            end
            L_NORM8: begin
                if (r_x[63:56] == 8'd0) begin
                    n_x  = r_x << 8;
                    n_sh = r_sh + 6'd8;
                end else begin
                    n_state = L_NORM1;
                end
            end
            L_NORM1: begin
                if (!r_x[63]) begin
                    n_x  = r_x << 1;
                    n_sh = r_sh + 6'd1;
                end else begin
                    n_m     = r_x[63:32];
                    n_fr    = '0;
                    n_i     = '0;
                    n_state = L_FRAC;
                end
            end
            L_FRAC: begin
                // one fraction bit per squaring
                n_fr = {r_fr[14:0], w_t[32]};
                n_m  = w_t[32] ? w_t[32:1] : w_t[31:0];
                n_i  = r_i + 4'd1;
                if (r_i == 4'd15) begin
                    n_done  = 1'b1;
                    n_state = L_IDLE;
                end
            end
            default: n_state = L_IDLE;
        endcase
    end

    assign o_stat.busy = (r_state != L_IDLE);
    assign o_stat.done = r_done;
    assign o_stat.res  = {10'd0, 6'd63 - r_sh, r_fr};

endmodule
`default_nettype wire
